### hw/rtl/assert_macros.svh
// Assertion macros for the RTL of the sign command packet checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// When ante holds, cons must hold at the same edge.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst, cond, msg)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)

`endif

`endif

### hw/rtl/scpc_pkg.sv
// Types and constants of the sign command packet checker.
`timescale 1ns / 1ps
`default_nettype none

package scpc_pkg;

  localparam int HEADER_BYTES = 8;

  // Command codes in header byte 2
  localparam logic [7:0] CMD_ON     = 8'd0;
  localparam logic [7:0] CMD_BRIGHT = 8'd1;
  localparam logic [7:0] CMD_IMAGE  = 8'd2;
  localparam logic [7:0] CMD_SLIDE  = 8'd3;
  localparam logic [7:0] CMD_STATUS = 8'd5;
  localparam logic [7:0] CMD_OFF    = 8'd126;

  // Required lengths: header + command byte overhead + payload
  localparam logic [15:0] IMAGE_LEN = 16'd585;
  localparam logic [15:0] SLIDE_LEN = 16'd1161;

  localparam logic [7:0] IMAGE_COUNT = 8'd1;
  localparam logic [7:0] SLIDE_COUNT = 8'd2;

  typedef enum logic [2:0] {
    ACT_NONE   = 3'd0,
    ACT_ON     = 3'd1,
    ACT_OFF    = 3'd2,
    ACT_IMAGE  = 3'd3,
    ACT_SLIDE  = 3'd4,
    ACT_STATUS = 3'd5
  } action_t;

  typedef struct packed {
    logic [15:0] length;
    logic [7:0]  command;
    logic [7:0]  brightness;
    logic [15:0] parameter_val;
    logic [7:0]  count;
  } hdr_t;

  typedef struct packed {
    logic        accepted;
    action_t     action;
    logic [7:0]  brightness;
    logic [15:0] delay;
  } result_t;

endpackage

`default_nettype wire

### hw/rtl/sign_command_packet_checker.sv
// Top level of the sign command packet checker: byte stream in, one verdict per packet out.
// Throughput: one byte per clock; a byte is taken every cycle unless two verdicts wait.
// The verdict is registered into the output register, or into the skid entry while the output register is full.
// Result side holds an output register plus one skid entry, so a stalled verdict
// does not stop the byte stream until a second verdict is also waiting.
// Reset (rst, synchronous, active high) clears the packet state and empties both result slots.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sign_command_packet_checker #(
  parameter int MAX_PACKET_BYTES = 2048
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // byte channel
  input  wire logic        byte_valid,
  output logic             byte_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        final_byte,
  // verdict channel
  output logic             result_valid,
  input  wire logic        result_ready,
  output logic             accepted,
  output logic [2:0]       action,
  output logic [7:0]       brightness,
  output logic [15:0]      delay
);
  import scpc_pkg::*;

  // Count must be able to hold MAX_PACKET_BYTES itself (saturation value).
  localparam int CNT_W  = $clog2(MAX_PACKET_BYTES + 1);
  localparam int CNT1_W = CNT_W + 1;
  localparam int CMP_W  = (CNT1_W > 16) ? CNT1_W : 16;

  // ---------------------------------------------------------------------------
  // Packet state
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0] byte_count;
  logic [15:0]      running_sum;
  logic [7:0]       previous_byte;
  logic [7:0]       byte_before_previous;
  hdr_t             hdr;
  logic             too_long;

  logic             take_byte;
  logic [15:0]      sum_next;
  logic [15:0]      sum_total;
  logic [CNT1_W-1:0] n_rcvd;
  logic [15:0]      rx_checksum;
  logic             len_match;
  logic             pkt_ok;
  result_t          verdict;

  assign take_byte = byte_valid && byte_ready;

  // Byte leaving the two-byte window joins the sum once two bytes are held.
  assign sum_total = running_sum + {8'd0, byte_before_previous};
  assign sum_next  = (byte_count >= CNT_W'(2)) ? sum_total : running_sum;

  // Checks on the final byte. For any packet of eight or more bytes the
  // window byte always joins the sum, so sum_total is the full sum there.
  assign n_rcvd      = {1'b0, byte_count} + CNT1_W'(1);
  assign rx_checksum = {data_byte, previous_byte};
  assign len_match   = (CMP_W'(hdr.length) == CMP_W'(n_rcvd));
  assign pkt_ok      = !too_long
                    && (byte_count >= CNT_W'(HEADER_BYTES - 1))
                    && (n_rcvd < CNT1_W'(MAX_PACKET_BYTES))
                    && len_match
                    && (rx_checksum == sum_total);

  scpc_decode u_decode (
    .ok  (pkt_ok),
    .hdr (hdr),
    .res (verdict)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count           <= '0;
      running_sum          <= '0;
      previous_byte        <= '0;
      byte_before_previous <= '0;
      hdr                  <= '0;
      too_long             <= 1'b0;
    end else if (take_byte) begin
      if (final_byte) begin
        // verdict issued; start clean for the next packet
        byte_count           <= '0;
        running_sum          <= '0;
        previous_byte        <= '0;
        byte_before_previous <= '0;
        hdr                  <= '0;
        too_long             <= 1'b0;
      end else begin
        running_sum          <= sum_next;
        byte_before_previous <= previous_byte;
        previous_byte        <= data_byte;
        if (byte_count == CNT_W'(MAX_PACKET_BYTES)) begin
          too_long <= 1'b1;
        end else begin
          byte_count <= byte_count + CNT_W'(1);
        end
        // header capture, little-endian fields
        unique case (byte_count)
          CNT_W'(0): hdr.length[7:0]         <= data_byte;
          CNT_W'(1): hdr.length[15:8]        <= data_byte;
          CNT_W'(2): hdr.command             <= data_byte;
          CNT_W'(3): hdr.brightness          <= data_byte;
          CNT_W'(4): hdr.parameter_val[7:0]  <= data_byte;
          CNT_W'(5): hdr.parameter_val[15:8] <= data_byte;
          CNT_W'(6): hdr.count               <= data_byte;
          default: ;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result register plus skid entry
  // ---------------------------------------------------------------------------
  logic    out_valid;
  logic    skid_valid;
  result_t out_res;
  result_t skid_res;
  logic    new_result;
  logic    fire_out;
  logic    load_out;
  logic    load_skid;

  assign byte_ready = !skid_valid;
  assign new_result = take_byte && final_byte;
  assign fire_out   = out_valid && result_ready;
  assign load_skid  = new_result && out_valid && !fire_out;
  assign load_out   = new_result && !load_skid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        // no new transaction can arrive while the skid entry is full
        if (fire_out) begin
          skid_valid <= 1'b0;
        end
      end else if (load_skid) begin
        skid_valid <= 1'b1;
      end else if (load_out) begin
        out_valid <= 1'b1;
      end else if (fire_out) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid && fire_out) begin
      out_res <= skid_res;
    end else if (load_out) begin
      out_res <= verdict;
    end
    if (load_skid) begin
      skid_res <= verdict;
    end
  end

  assign result_valid = out_valid;
  assign accepted     = out_res.accepted;
  assign action       = out_res.action;
  assign brightness   = out_res.brightness;
  assign delay        = out_res.delay;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  logic count_in_range;
  logic reject_out;
  logic reject_is_clean;
  logic delay_only_slide;

  assign count_in_range   = (byte_count <= CNT_W'(MAX_PACKET_BYTES));
  assign reject_out       = out_valid && !out_res.accepted;
  assign reject_is_clean  = (out_res.action == ACT_NONE) && (out_res.brightness == 8'd0)
                         && (out_res.delay == 16'd0);
  assign delay_only_slide = (out_res.action == ACT_SLIDE) || (out_res.delay == 16'd0);

  `ASSERT_IMPLIES(a_skid_behind_out, clk, rst, skid_valid, out_valid, "skid without output")
  `ASSERT_ALWAYS(a_count_bound, clk, rst, count_in_range, "byte count past max")
  `ASSERT_IMPLIES(a_reject_clean, clk, rst, reject_out, reject_is_clean, "reject has data")
  `ASSERT_IMPLIES(a_delay_slide_only, clk, rst, out_valid, delay_only_slide, "stray delay")

endmodule

`default_nettype wire

### hw/rtl/scpc_decode.sv
// Command decode: turns the captured header of a checked packet into a verdict.
`timescale 1ns / 1ps
`default_nettype none

module scpc_decode (
  input  wire logic             ok,
  input  wire scpc_pkg::hdr_t   hdr,
  output scpc_pkg::result_t     res
);
  import scpc_pkg::*;

  always_comb begin
    res            = '0;
    res.action     = ACT_NONE;
    res.accepted   = ok;
    if (ok) begin
      unique case (hdr.command)
        CMD_ON: begin
          res.action     = ACT_ON;
          res.brightness = hdr.brightness;
        end
        CMD_BRIGHT: begin
          if (hdr.brightness != 8'd0) begin
            res.action     = ACT_ON;
            res.brightness = hdr.brightness;
          end else begin
            res.action = ACT_OFF;
          end
        end
        CMD_OFF: begin
          res.action = ACT_OFF;
        end
        CMD_STATUS: begin
          res.action = ACT_STATUS;
        end
        CMD_IMAGE: begin
          if (hdr.length == IMAGE_LEN && hdr.count == IMAGE_COUNT) begin
            res.action     = ACT_IMAGE;
            res.brightness = hdr.brightness;
          end
        end
        CMD_SLIDE: begin
          if (hdr.length == SLIDE_LEN && hdr.count == SLIDE_COUNT) begin
            res.action     = ACT_SLIDE;
            res.brightness = hdr.brightness;
            res.delay      = hdr.parameter_val;
          end
        end
        default: begin
          res.action = ACT_NONE;  // unknown codes and clip command
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### bench/scpc_verdict_checker.sv
// Verdict checker for the sign command packet checker: predicts each verdict and compares it.
`timescale 1ns / 1ps

module scpc_verdict_checker #(
  parameter int MAX_BYTES = 2048
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        byte_valid,
  input  wire logic        byte_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        final_byte,
  input  wire logic        result_valid,
  input  wire logic        result_ready,
  input  wire logic        accepted,
  input  wire logic [2:0]  action,
  input  wire logic [7:0]  brightness,
  input  wire logic [15:0] delay,
  output int               fail_count,
  output int               pending
);
  import scpc_pkg::*;

  // per-packet state, cleared on every final byte
  int unsigned rx_count;
  logic [15:0] body_sum;
  logic [7:0]  last_b;
  logic [7:0]  prior_b;
  hdr_t        hdr;
  logic        overrun;

  result_t verdict_q[$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic report(input string what, input logic [15:0] want, input logic [15:0] got);
    $display("MISMATCH %s: expected %0h got %0h at %0t", what, want, got, $time);
    fail_count++;
  endtask

  task automatic clear_packet();
    rx_count = 0;
    body_sum = '0;
    last_b   = '0;
    prior_b  = '0;
    hdr      = '0;
    overrun  = 1'b0;
  endtask

  function automatic result_t judge_packet(input int unsigned n, input logic [15:0] tail_cs,
                                           input logic [15:0] sum);
    result_t v;
    logic    ok;
    v  = '0;
    ok = !overrun && n >= HEADER_BYTES && n < MAX_BYTES && {16'd0, hdr.length} == n
         && tail_cs == sum;
    if (ok) begin
      v.accepted = 1'b1;
      case (hdr.command)
        CMD_ON: begin
          v.action     = ACT_ON;
          v.brightness = hdr.brightness;
        end
        CMD_BRIGHT: begin
          if (hdr.brightness != 8'd0) begin
            v.action     = ACT_ON;
            v.brightness = hdr.brightness;
          end else begin
            v.action = ACT_OFF;
          end
        end
        CMD_OFF:    v.action = ACT_OFF;
        CMD_STATUS: v.action = ACT_STATUS;
        CMD_IMAGE: begin
          if (hdr.length == IMAGE_LEN && hdr.count == IMAGE_COUNT) begin
            v.action     = ACT_IMAGE;
            v.brightness = hdr.brightness;
          end
        end
        CMD_SLIDE: begin
          if (hdr.length == SLIDE_LEN && hdr.count == SLIDE_COUNT) begin
            v.action     = ACT_SLIDE;
            v.brightness = hdr.brightness;
            v.delay      = hdr.parameter_val;
          end
        end
        default: v.action = ACT_NONE;
      endcase
    end
    return v;
  endfunction

  // one byte into the packet state; a final byte yields a verdict
  task automatic absorb_byte(input logic [7:0] b, input logic fin);
    int unsigned idx;
    logic [15:0] sum;
    idx = rx_count;
    sum = body_sum;
    case (idx)
      0: hdr.length[7:0]         = b;
      1: hdr.length[15:8]        = b;
      2: hdr.command             = b;
      3: hdr.brightness          = b;
      4: hdr.parameter_val[7:0]  = b;
      5: hdr.parameter_val[15:8] = b;
      6: hdr.count               = b;
      default: ;
    endcase
    // the checksum window lags two bytes behind
    if (idx >= 2)
      sum = sum + {8'd0, prior_b};
    if (!fin) begin
      body_sum = sum;
      prior_b  = last_b;
      last_b   = b;
      if (rx_count < MAX_BYTES)
        rx_count++;
      else
        overrun = 1'b1;
    end else begin
      verdict_q.push_back(judge_packet(idx + 1, {b, last_b}, sum));
      clear_packet();
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      clear_packet();
      verdict_q.delete();
    end else begin
      if (result_valid && result_ready) begin
        if (verdict_q.size() == 0) begin
          report("verdict with no packet pending", 16'd0, {15'd0, accepted});
        end else begin
          want = verdict_q.pop_front();
          if (accepted !== want.accepted)
            report("accepted", {15'd0, want.accepted}, {15'd0, accepted});
          if (action !== want.action)
            report("action", {13'd0, want.action}, {13'd0, action});
          if (brightness !== want.brightness)
            report("brightness", {8'd0, want.brightness}, {8'd0, brightness});
          if (delay !== want.delay)
            report("delay", want.delay, delay);
        end
      end
      if (byte_valid && byte_ready)
        absorb_byte(data_byte, final_byte);
    end
    pending = verdict_q.size();
  end

endmodule

### bench/tb_sign_command_packet_checker.sv
// Testbench top for the sign command packet checker: packet stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_sign_command_packet_checker;
  import scpc_pkg::*;

  localparam int MAX_BYTES       = 2048;
  // the package has no name for the clip command; it must decode to no action
  localparam logic [7:0] CMD_CLIP = 8'd4;
  localparam int HOLD_OFF_CYCLES = 400;
  // no transaction on either channel for this long means the block is hung
  localparam int IDLE_LIMIT      = 4000;
  localparam int RANDOM_BYTES    = 620;
  localparam int RANDOM_PACKETS  = 30;

  typedef logic [7:0] byte_q_t[$];

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        byte_valid   = 1'b0;
  logic        byte_ready;
  logic [7:0]  data_byte    = 8'd0;
  logic        final_byte   = 1'b0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  logic        accepted;
  logic [2:0]  action;
  logic [7:0]  brightness;
  logic [15:0] delay;

  int fails;
  int pending;

  // sender burst bookkeeping
  int burst_left   = 0;
  int rnd_bytes    = 0;
  int rnd_packets  = 0;

  // receiver side
  logic        hold_off_go   = 1'b0;
  bit          hold_used     = 1'b0;
  int          hold_left     = 0;
  int unsigned rcv_cycle     = 0;
  int          idle_cycles   = 0;

  sign_command_packet_checker #(
    .MAX_PACKET_BYTES(MAX_BYTES)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_ready   (byte_ready),
    .data_byte    (data_byte),
    .final_byte   (final_byte),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .accepted     (accepted),
    .action       (action),
    .brightness   (brightness),
    .delay        (delay)
  );

  scpc_verdict_checker #(
    .MAX_BYTES(MAX_BYTES)
  ) verdict_chk (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_ready   (byte_ready),
    .data_byte    (data_byte),
    .final_byte   (final_byte),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .accepted     (accepted),
    .action       (action),
    .brightness   (brightness),
    .delay        (delay),
    .fail_count   (fails),
    .pending      (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Verdict receiver. The stall pattern steps through phases, from always ready
  // through random and periodic stalls. One long hold-off is armed by the
  // stimulus so that two verdicts pile up and the byte input backs up.
  always @(negedge clk) begin
    if (hold_off_go && !hold_used) begin
      hold_used = 1'b1;
      hold_left = HOLD_OFF_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_ready <= 1'b0;
    end else begin
      case (rcv_cycle[8:6])
        3'd0, 3'd1: result_ready <= 1'b1;
        3'd2:       result_ready <= 1'($urandom_range(0, 1));
        3'd3:       result_ready <= ($urandom_range(0, 3) == 0);
        3'd4:       result_ready <= (rcv_cycle[2:0] != 3'd0);
        3'd5:       result_ready <= rcv_cycle[3];
        default:    result_ready <= ($urandom_range(0, 4) != 0);
      endcase
    end
    rcv_cycle++;
  end

  // Watchdog: counts cycles with no transaction on either channel.
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((byte_valid && byte_ready) || (result_valid && result_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Offer one byte and hold it until taken. Called at a falling edge and
  // returns at a falling edge. Bursts of random length alternate with gaps;
  // some bursts are long so stretches run without any idling.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        byte_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 20);
    end
    byte_valid <= 1'b1;
    data_byte  <= b;
    final_byte <= fin;
    do @(posedge clk); while (!byte_ready);
    @(negedge clk);
    burst_left--;
  endtask

  task automatic send_bytes(input byte_q_t p);
    foreach (p[i])
      send_byte(p[i], i == p.size() - 1);
  endtask

  // Build an n-byte command packet: header, random payload and trailing
  // checksum. len_flip and cs_flip corrupt the length field and checksum.
  // Below 9 bytes the checksum overlaps the header, as it does on the wire.
  task automatic send_command(input int n, input logic [7:0] cmd, input logic [7:0] bright,
                              input logic [15:0] param, input logic [7:0] count,
                              input logic [15:0] len_flip, input logic [7:0] cs_flip);
    byte_q_t     p;
    logic [7:0]  hdr_b[7];
    logic [15:0] len;
    logic [15:0] cs;
    len   = n[15:0] ^ len_flip;
    hdr_b = '{len[7:0], len[15:8], cmd, bright, param[7:0], param[15:8], count};
    for (int i = 0; i < n; i++)
      p.push_back((i < 7) ? hdr_b[i] : 8'($urandom_range(0, 255)));
    if (n >= 2) begin
      cs = '0;
      for (int i = 0; i < n - 2; i++)
        cs = cs + {8'd0, p[i]};
      cs[7:0] = cs[7:0] ^ cs_flip;
      p[n-2]  = cs[7:0];
      p[n-1]  = cs[15:8];
    end
    send_bytes(p);
  endtask

  task automatic send_noise(input int n);
    byte_q_t p;
    for (int i = 0; i < n; i++)
      p.push_back(8'($urandom_range(0, 255)));
    send_bytes(p);
  endtask

  function automatic logic [7:0] pick_command();
    case ($urandom_range(0, 7))
      0:       return CMD_ON;
      1:       return CMD_BRIGHT;
      2:       return CMD_IMAGE;
      3:       return CMD_SLIDE;
      4:       return CMD_STATUS;
      5:       return CMD_OFF;
      6:       return CMD_CLIP;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    int r;
    int n;
    logic [7:0] bright;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed packets: every command, brightness and parameter extremes,
    // the minimum length, short packets, bad length and bad checksum.
    send_command(8,  CMD_ON,     8'hFF, 16'hFFFF, 8'hFF, 16'h0, 8'h0);
    send_command(8,  CMD_ON,     8'h00, 16'h0000, 8'h00, 16'h0, 8'h0);
    send_command(9,  CMD_BRIGHT, 8'h80, 16'h1234, 8'h01, 16'h0, 8'h0);
    send_command(9,  CMD_BRIGHT, 8'h00, 16'h1234, 8'h01, 16'h0, 8'h0);
    send_command(10, CMD_OFF,    8'h55, 16'hFFFF, 8'h02, 16'h0, 8'h0);
    send_command(8,  CMD_STATUS, 8'hAA, 16'hFFFF, 8'h00, 16'h0, 8'h0);
    // image and slide commands with the wrong length decode to no action
    send_command(12, CMD_IMAGE,  8'h7F, 16'h0001, IMAGE_COUNT, 16'h0, 8'h0);
    send_command(12, CMD_SLIDE,  8'h7F, 16'hFFFF, SLIDE_COUNT, 16'h0, 8'h0);
    send_command(11, CMD_CLIP,   8'h10, 16'h0, 8'h00, 16'h0, 8'h0);
    send_command(11, 8'hFF,      8'h10, 16'h0, 8'h00, 16'h0, 8'h0);
    // bad checksum, bad length
    send_command(10, CMD_ON,     8'h44, 16'h0, 8'h00, 16'h0, 8'h01);
    send_command(10, CMD_ON,     8'h44, 16'h0, 8'h00, 16'h8000, 8'h0);
    // short packets are rejected even when self-consistent
    send_command(7,  CMD_ON,     8'h44, 16'h0, 8'h00, 16'h0, 8'h0);
    send_command(2,  CMD_ON,     8'h44, 16'h0, 8'h00, 16'h0, 8'h0);
    send_command(1,  CMD_ON,     8'h44, 16'h0, 8'h00, 16'h0, 8'h0);

    // Random small packets. The receiver holds off at the start of this
    // phase while the sender keeps going, so the result slots fill.
    hold_off_go = 1'b1;
    while (rnd_bytes < RANDOM_BYTES || rnd_packets < RANDOM_PACKETS) begin
      r      = $urandom_range(0, 99);
      n      = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 64) : $urandom_range(8, 24);
      bright = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
      if (r < 60) begin
        send_command(n, pick_command(), bright, 16'($urandom_range(0, 65535)),
                     8'($urandom_range(0, 3)), 16'h0, 8'h0);
      end else if (r < 72) begin
        send_command(n, pick_command(), bright, 16'($urandom_range(0, 65535)),
                     8'($urandom_range(0, 3)), 16'h0, 8'($urandom_range(1, 255)));
      end else if (r < 82) begin
        send_command(n, pick_command(), bright, 16'($urandom_range(0, 65535)),
                     8'($urandom_range(0, 3)), 16'($urandom_range(1, 65535)), 8'h0);
      end else if (r < 90) begin
        n = $urandom_range(1, 7);
        send_command(n, pick_command(), bright, 16'($urandom_range(0, 65535)),
                     8'($urandom_range(0, 3)), 16'h0, 8'h0);
      end else begin
        n = $urandom_range(1, 30);
        send_noise(n);
      end
      rnd_bytes   += n;
      rnd_packets++;
    end
    byte_valid <= 1'b0;

    // drain: every verdict in, then a wait for anything stray
    wait (pending == 0);
    repeat (8) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### sign_command_packet_checker.f
+incdir+hw/rtl
hw/rtl/scpc_pkg.sv
hw/rtl/scpc_decode.sv
hw/rtl/sign_command_packet_checker.sv
bench/scpc_verdict_checker.sv
bench/tb_sign_command_packet_checker.sv
